FILE: rtl/utf8_display_escaper_core_assert.svh
// Assertion macros shared by the display escaper RTL files.
`ifndef UTF8_DISPLAY_ESCAPER_CORE_ASSERT_SVH
`define UTF8_DISPLAY_ESCAPER_CORE_ASSERT_SVH

// Checks a condition at every clock edge outside reset.
`define UDE_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Checks that a condition in the next cycle follows from a trigger.
`define UDE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ude_pkg.sv
// Shared types, constants and functions of the display escaper.
`timescale 1ns / 1ps

package ude_pkg;

  localparam int unsigned MaxResults   = 5;
  localparam int unsigned QueueDepthDef = 4;

  localparam logic [7:0] LeadTwoMin    = 8'hC2;
  localparam logic [7:0] LeadTwoMax    = 8'hDF;
  localparam logic [7:0] LeadThreeMin  = 8'hE0;
  localparam logic [7:0] LeadThreeMax  = 8'hEF;
  localparam logic [7:0] LeadFourMin   = 8'hF0;
  localparam logic [7:0] LeadFourMax   = 8'hF4;

  localparam logic [7:0] CharQuote     = 8'h22;
  localparam logic [7:0] CharBackslash = 8'h5C;
  localparam logic [7:0] CharNewline   = 8'h0A;
  localparam logic [7:0] CharReturn    = 8'h0D;
  localparam logic [7:0] CharTab       = 8'h09;
  localparam logic [7:0] CharLetterN   = 8'h6E;
  localparam logic [7:0] CharLetterR   = 8'h72;
  localparam logic [7:0] CharLetterT   = 8'h74;
  localparam logic [7:0] CharQuestion  = 8'h3F;
  localparam logic [7:0] CharDelete    = 8'h7F;
  localparam logic [7:0] CharSpace     = 8'h20;

  // Length of the open UTF-8 sequence; none when nothing is held.
  localparam logic [2:0] SeqNone  = 3'd0;
  localparam logic [2:0] SeqTwo   = 3'd2;
  localparam logic [2:0] SeqThree = 3'd3;
  localparam logic [2:0] SeqFour  = 3'd4;

  localparam logic [1:0] ColsNone   = 2'd0;
  localparam logic [1:0] ColsSingle = 2'd1;
  localparam logic [1:0] ColsDouble = 2'd2;

  // One queued command: the result bytes that one input byte causes.
  typedef struct packed {
    logic [MaxResults-1:0][7:0] data_b;
    logic [MaxResults-1:0][1:0] col_w;
    logic [2:0]                 count;
  } ude_cmd_t;

  // Appends one result to a command.
  function automatic ude_cmd_t push_res(ude_cmd_t c, logic [7:0] b, logic [1:0] w);
    ude_cmd_t r;
    r = c;
    if (c.count < 3'(MaxResults)) begin
      r.data_b[c.count] = b;
      r.col_w[c.count]  = w;
      r.count           = c.count + 3'd1;
    end
    return r;
  endfunction

  // Display columns of a code point.
  function automatic logic [1:0] columns_of(logic [20:0] v);
    logic [1:0] cols;
    cols = ColsSingle;
    if ((v >= 21'h00300 && v <= 21'h0036F) || (v >= 21'h01AB0 && v <= 21'h01AFF) ||
        (v >= 21'h01DC0 && v <= 21'h01DFF) || (v >= 21'h020D0 && v <= 21'h020FF) ||
        (v >= 21'h0FE00 && v <= 21'h0FE0F) || (v >= 21'h0FE20 && v <= 21'h0FE2F)) begin
      cols = ColsNone;
    end else if ((v >= 21'h01100 && v <= 21'h0115F) || v == 21'h02329 ||
                 v == 21'h0232A || (v >= 21'h02E80 && v <= 21'h0A4CF) ||
                 (v >= 21'h0AC00 && v <= 21'h0D7A3) || (v >= 21'h0F900 && v <= 21'h0FAFF) ||
                 (v >= 21'h0FE10 && v <= 21'h0FE19) || (v >= 21'h0FE30 && v <= 21'h0FE6F) ||
                 (v >= 21'h0FF00 && v <= 21'h0FF60) || (v >= 21'h0FFE0 && v <= 21'h0FFE6) ||
                 (v >= 21'h1F300 && v <= 21'h1FAFF) ||
                 (v >= 21'h20000 && v <= 21'h3FFFD)) begin
      cols = ColsDouble;
    end
    return cols;
  endfunction

endpackage

FILE: rtl/ude_front.sv
// Front end: classifies text bytes, tracks UTF-8 sequences, builds commands.
`timescale 1ns / 1ps

module ude_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        text_byte_i,
  input  logic              text_end_i,
  output logic              push_o,
  output ude_pkg::ude_cmd_t cmd_o
);
  import ude_pkg::*;

  logic [2:0][7:0] held_q, held_d;
  logic [1:0]      held_count_q, held_count_d;
  logic [2:0]      seq_len_q, seq_len_d;
  logic [20:0]     cp_q, cp_d;
  logic [20:0]     cp_next;
  logic            seq_ok;
  ude_cmd_t        cmd;

  assign cp_next = {cp_q[14:0], text_byte_i[5:0]};

  always_comb begin
    held_d       = held_q;
    held_count_d = held_count_q;
    seq_len_d    = seq_len_q;
    cp_d         = cp_q;
    cmd          = '0;
    seq_ok       = 1'b1;

    if (held_count_q != 2'd0 && text_byte_i[7:6] == 2'b10) begin
      if (({1'b0, held_count_q} + 3'd1) >= seq_len_q) begin
        // Sequence complete: reject surrogates, overlong and out-of-range forms.
        if (seq_len_q == SeqThree &&
            ((cp_next >= 21'h00D800 && cp_next <= 21'h00DFFF) || cp_next < 21'h000800)) begin
          seq_ok = 1'b0;
        end
        if (seq_len_q == SeqFour && (cp_next > 21'h10FFFF || cp_next < 21'h010000)) begin
          seq_ok = 1'b0;
        end
        if (seq_ok) begin
          cmd = push_res(cmd, held_q[0], columns_of(cp_next));
          for (int i = 1; i < 3; i++) begin
            if (2'(i) < held_count_q) cmd = push_res(cmd, held_q[i], ColsNone);
          end
          cmd = push_res(cmd, text_byte_i, ColsNone);
        end else begin
          for (int i = 0; i < 3; i++) begin
            if (2'(i) < held_count_q) cmd = push_res(cmd, CharQuestion, ColsSingle);
          end
          cmd = push_res(cmd, CharQuestion, ColsSingle);
        end
        held_count_d = 2'd0;
        seq_len_d    = SeqNone;
        cp_d         = '0;
      end else begin
        held_d[held_count_q] = text_byte_i;
        held_count_d         = held_count_q + 2'd1;
        cp_d                 = cp_next;
      end
    end else begin
      // A broken sequence gives one '?' per held byte.
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < held_count_q) cmd = push_res(cmd, CharQuestion, ColsSingle);
      end
      held_count_d = 2'd0;
      seq_len_d    = SeqNone;
      cp_d         = '0;

      if (!text_byte_i[7]) begin
        case (text_byte_i)
          CharQuote, CharBackslash: begin
            cmd = push_res(cmd, CharBackslash, ColsSingle);
            cmd = push_res(cmd, text_byte_i, ColsSingle);
          end
          CharNewline: begin
            cmd = push_res(cmd, CharBackslash, ColsSingle);
            cmd = push_res(cmd, CharLetterN, ColsSingle);
          end
          CharReturn: begin
            cmd = push_res(cmd, CharBackslash, ColsSingle);
            cmd = push_res(cmd, CharLetterR, ColsSingle);
          end
          CharTab: begin
            cmd = push_res(cmd, CharBackslash, ColsSingle);
            cmd = push_res(cmd, CharLetterT, ColsSingle);
          end
          default: begin
            if (text_byte_i < CharSpace || text_byte_i == CharDelete) begin
              cmd = push_res(cmd, CharQuestion, ColsSingle);
            end else begin
              cmd = push_res(cmd, text_byte_i, ColsSingle);
            end
          end
        endcase
      end else if (text_byte_i >= LeadTwoMin && text_byte_i <= LeadTwoMax) begin
        seq_len_d    = SeqTwo;
        cp_d         = {16'd0, text_byte_i[4:0]};
        held_d[0]    = text_byte_i;
        held_count_d = 2'd1;
      end else if (text_byte_i >= LeadThreeMin && text_byte_i <= LeadThreeMax) begin
        seq_len_d    = SeqThree;
        cp_d         = {17'd0, text_byte_i[3:0]};
        held_d[0]    = text_byte_i;
        held_count_d = 2'd1;
      end else if (text_byte_i >= LeadFourMin && text_byte_i <= LeadFourMax) begin
        seq_len_d    = SeqFour;
        cp_d         = {18'd0, text_byte_i[2:0]};
        held_d[0]    = text_byte_i;
        held_count_d = 2'd1;
      end else begin
        cmd = push_res(cmd, CharQuestion, ColsSingle);
      end
    end

    // At the end of the text every byte still held becomes '?'.
    if (text_end_i) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < held_count_d) cmd = push_res(cmd, CharQuestion, ColsSingle);
      end
      held_count_d = 2'd0;
      seq_len_d    = SeqNone;
      cp_d         = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_count_q <= 2'd0;
      seq_len_q    <= SeqNone;
      cp_q         <= '0;
    end else if (accept_i) begin
      held_count_q <= held_count_d;
      seq_len_q    <= seq_len_d;
      cp_q         <= cp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) held_q <= held_d;
  end

  assign push_o = accept_i && (cmd.count != 3'd0);
  assign cmd_o  = cmd;

  `include "utf8_display_escaper_core_assert.svh"

  `UDE_ASSERT(a_open_consistent, (held_count_q == 2'd0) == (seq_len_q == SeqNone), "held count and sequence length disagree")
  `UDE_ASSERT(a_held_below_len, (held_count_q == 2'd0) || ({1'b0, held_count_q} < seq_len_q), "held bytes reach sequence length")

endmodule

FILE: rtl/ude_cmd_queue.sv
// Short command queue between the front end and the output expander.
`timescale 1ns / 1ps

module ude_cmd_queue #(
  parameter int unsigned Depth = ude_pkg::QueueDepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ude_pkg::ude_cmd_t push_cmd_i,
  input  logic              pop_i,
  output logic              full_o,
  output logic              empty_o,
  output ude_pkg::ude_cmd_t head_o
);
  import ude_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  ude_cmd_t        entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign head_o  = entries_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    if (do_pop)  rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    if (do_push && !do_pop) count_d = count_q + CntW'(1);
    if (do_pop && !do_push) count_d = count_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) entries_q[wr_ptr_q] <= push_cmd_i;
  end

  `include "utf8_display_escaper_core_assert.svh"

  `UDE_ASSERT(a_count_bound, count_q <= CntW'(Depth), "queue count above depth")
  `UDE_ASSERT_NEXT(a_count_grows, do_push && !do_pop, count_q == $past(count_q) + CntW'(1), "queue count did not grow on push")

endmodule

FILE: rtl/ude_back.sv
// Back end: expands queued commands into single result bytes.
`timescale 1ns / 1ps

module ude_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  ude_pkg::ude_cmd_t head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_byte_o,
  output logic [1:0]        char_width_o,
  output logic              run_last_o
);
  import ude_pkg::*;

  logic [2:0] idx_q;
  logic       valid_q;
  logic [7:0] byte_q;
  logic [1:0] width_q;
  logic       last_q;
  logic       load;
  logic       slot_last;

  // The output register refills whenever it is empty or being drained.
  assign load      = !empty_i && (!valid_q || out_ready_i);
  assign slot_last = ((idx_q + 3'd1) == head_i.count);
  assign pop_o     = load && slot_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 3'd0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= slot_last ? 3'd0 : idx_q + 3'd1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q  <= head_i.data_b[idx_q];
      width_q <= head_i.col_w[idx_q];
      last_q  <= slot_last;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_byte_o   = byte_q;
  assign char_width_o = width_q;
  assign run_last_o   = last_q;

  `include "utf8_display_escaper_core_assert.svh"

  `UDE_ASSERT(a_idx_in_cmd, empty_i || (idx_q < head_i.count), "slot index beyond command length")

endmodule

FILE: rtl/utf8_display_escaper_core.sv
// Top level of the UTF-8 display escaper.
//
// The block takes a text one byte per transaction on the slave stream and gives
// escaped display bytes on the master stream. s_axis_tdata carries the text
// byte and s_axis_tlast marks the last byte of a text. Each result carries the
// display byte, the column width of the character it starts (zero on the
// trailing bytes of a multi-byte character) and, in m_axis_tlast, a flag on
// the last result caused by one input byte. An input byte that only opens or
// extends a UTF-8 sequence causes no result.
// The front end classifies a byte in the cycle it is accepted and writes the
// one to five results it causes into a command queue of QueueDepth entries.
// The back end drains one result per cycle, while the receiver is ready, into
// the output register; the first result of a transaction is registered first
// in the queue entry and then in the output register. The block accepts a byte
// in every cycle while the queue has room; the output side sets the sustained
// rate at one result per cycle, also for bytes that cause escapes or flush a broken sequence.
// When the receiver stalls, the output register holds its transaction, the
// queue fills and s_axis_tready drops once it is full.
// Reset clears the sequence tracker, the queue and the output register; there
// is no clearing pass and the block is ready in the first cycle after reset.
`timescale 1ns / 1ps

module utf8_display_escaper_core #(
  parameter int unsigned QueueDepth = ude_pkg::QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  logic        s_axis_tlast,   // text_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [9:8] char_width, rest zero
  output logic        m_axis_tlast    // run_last
);
  import ude_pkg::*;

  logic     accept;
  logic     q_push;
  logic     q_pop;
  logic     q_full;
  logic     q_empty;
  ude_cmd_t push_cmd;
  ude_cmd_t head_cmd;
  logic [7:0] out_byte;
  logic [1:0] char_width;

  // A byte is taken whenever the queue can hold the command it may cause.
  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  ude_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .text_byte_i (s_axis_tdata),
    .text_end_i  (s_axis_tlast),
    .push_o      (q_push),
    .cmd_o       (push_cmd)
  );

  ude_cmd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (push_cmd),
    .pop_i      (q_pop),
    .full_o     (q_full),
    .empty_o    (q_empty),
    .head_o     (head_cmd)
  );

  ude_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (q_empty),
    .head_i       (head_cmd),
    .pop_o        (q_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_byte_o   (out_byte),
    .char_width_o (char_width),
    .run_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, char_width, out_byte};

  `include "utf8_display_escaper_core_assert.svh"

  // Every command written to the queue holds between one and five results.
  `UDE_ASSERT(a_push_count, !q_push || (push_cmd.count != 3'd0 && push_cmd.count <= 3'(MaxResults)), "pushed command has bad result count")

endmodule
